/* hdl/sfdm_pkg.sv */
// Package for the SBUS frame drive mixer: register codes, configuration bundle
// and the stage record passed from the frame collector to the mixer.
// No dependencies.
package sfdm_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int CH_W        = 11;
  localparam int DB_W        = 10;
  localparam int GAIN_W      = 6;
  localparam int OFS_W       = CH_W + 1;
  localparam int DRIVE_W     = 19;
  localparam int SHOVEL_W    = 18;
  localparam int RAW_CHANS   = 7;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CH_W-1:0]   CENTER_RST   = CH_W'(1024);
  localparam logic [CH_W-1:0]   FLOOR_RST    = CH_W'(300);
  localparam logic [DB_W-1:0]   DEADBAND_RST = DB_W'(75);
  localparam logic [GAIN_W-1:0] STRAIGHT_RST = GAIN_W'(24);
  localparam logic [GAIN_W-1:0] TURN_RST     = GAIN_W'(7);
  localparam logic [GAIN_W-1:0] SHOVEL_RST   = GAIN_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER,
    CFG_FLOOR,
    CFG_DEADBAND,
    CFG_STRAIGHT,
    CFG_TURN,
    CFG_SHOVEL
  } cfg_index_t;

  typedef struct packed {
    logic [CH_W-1:0]   center;
    logic [CH_W-1:0]   floor;
    logic [DB_W-1:0]   deadband;
    logic [GAIN_W-1:0] straight_gain;
    logic [GAIN_W-1:0] turn_gain;
    logic [GAIN_W-1:0] shovel_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [OFS_W-1:0]          turn_ofs;
    logic signed [OFS_W-1:0]          straight_ofs;
    logic signed [OFS_W-1:0]          shovel_ofs;
    logic [RAW_CHANS-1:0][CH_W-1:0]   raw;
  } frame_t;

endpackage

/* hdl/sfdm_collect.sv */
// Frame collector: byte position counter, frame store for bytes 1 to 14,
// channel unpacking and stick cleanup into one stage register.
// Depends on sfdm_pkg.
module sfdm_collect import sfdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_serial_byte,
  output logic             frame_valid,
  output frame_t           frame,
  input  logic             frame_ready
);

  localparam int FIRST_BYTE = 1;
  localparam int LAST_BYTE  = 14;

  logic [7:0]       store_r [FIRST_BYTE:LAST_BYTE];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             a_valid_r;
  logic             a_valid_nxt;
  frame_t           frame_r;
  frame_t           frame_nxt;
  logic             last_byte;
  logic             accept;
  logic [CH_W-1:0]  ch [0:9];

  function automatic logic signed [OFS_W-1:0] stick_ofs(
    input logic [CH_W-1:0] c,
    input cfg_t            k,
    input logic            use_db
  );
    logic signed [OFS_W-1:0] d;
    logic signed [OFS_W-1:0] db;
    logic signed [OFS_W-1:0] res;
    d   = $signed({1'b0, c}) - $signed({1'b0, k.center});
    db  = $signed({{(OFS_W-DB_W){1'b0}}, k.deadband});
    res = d;
    if (c < k.floor) begin
      res = '0;
    end else if (use_db && (d < db) && (d > -db)) begin
      res = '0;
    end
    return res;
  endfunction

  assign last_byte = (pos_r >= POS_W'(FRAME_BYTES - 1));
  assign in_stall  = a_valid_r && !frame_ready && last_byte;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = last_byte ? '0 : pos_r + POS_W'(1);
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept && last_byte) begin
      a_valid_nxt = 1'b1;
    end else if (frame_ready) begin
      a_valid_nxt = 1'b0;
    end
  end

  assign ch[0] = CH_W'({store_r[2], store_r[1]});
  assign ch[1] = CH_W'({store_r[3], store_r[2]} >> 3);
  assign ch[2] = CH_W'({store_r[5], store_r[4], store_r[3]} >> 6);
  assign ch[3] = CH_W'({store_r[6], store_r[5]} >> 1);
  assign ch[4] = CH_W'({store_r[7], store_r[6]} >> 4);
  assign ch[5] = CH_W'({store_r[9], store_r[8], store_r[7]} >> 7);
  assign ch[6] = CH_W'({store_r[10], store_r[9]} >> 2);
  assign ch[7] = CH_W'({store_r[11], store_r[10]} >> 5);
  assign ch[8] = CH_W'({store_r[13], store_r[12]});
  assign ch[9] = CH_W'({store_r[14], store_r[13]} >> 3);

  always_comb begin
    frame_nxt.turn_ofs     = stick_ofs(ch[0], cfg, 1'b1);
    frame_nxt.straight_ofs = stick_ofs(ch[1], cfg, 1'b1);
    frame_nxt.shovel_ofs   = stick_ofs(ch[2], cfg, 1'b0);
    for (int i = 0; i < RAW_CHANS; i++) begin
      frame_nxt.raw[i] = ch[i + 3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = FIRST_BYTE; i <= LAST_BYTE; i++) begin
      if (accept && (pos_r == POS_W'(i))) begin
        store_r[i] <= in_serial_byte;
      end
    end
    if (accept && last_byte) begin
      frame_r <= frame_nxt;
    end
  end

  assign frame_valid = a_valid_r;
  assign frame       = frame_r;

endmodule

/* hdl/sfdm_mix.sv */
// Drive mixer: scales the cleaned stick offsets by the gains, forms the left,
// right and shovel targets and holds the result register.
// Depends on sfdm_pkg.
module sfdm_mix import sfdm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       frame_valid,
  input  frame_t                     frame,
  output logic                       frame_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DRIVE_W-1:0]  left_target,
  output logic signed [DRIVE_W-1:0]  right_target,
  output logic signed [SHOVEL_W-1:0] shovel_target,
  output logic [RAW_CHANS-1:0][CH_W-1:0] raw
);

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          load;
  logic signed [DRIVE_W-1:0]     straight;
  logic signed [DRIVE_W-1:0]     turn;
  logic signed [SHOVEL_W-1:0]    shovel;
  logic signed [DRIVE_W-1:0]     left_r;
  logic signed [DRIVE_W-1:0]     right_r;
  logic signed [SHOVEL_W-1:0]    shovel_r;
  logic [RAW_CHANS-1:0][CH_W-1:0] raw_r;

  assign frame_ready = !out_valid_r || !out_stall;
  assign load        = frame_valid && frame_ready;

  assign straight = DRIVE_W'(frame.straight_ofs) *
                    DRIVE_W'($signed({1'b0, cfg.straight_gain}));
  assign turn     = DRIVE_W'(frame.turn_ofs) *
                    DRIVE_W'($signed({1'b0, cfg.turn_gain}));
  assign shovel   = SHOVEL_W'(frame.shovel_ofs) *
                    SHOVEL_W'($signed({1'b0, cfg.shovel_gain}));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r   <= straight + turn;
      right_r  <= turn - straight;
      shovel_r <= shovel;
      raw_r    <= frame.raw;
    end
  end

  assign out_valid     = out_valid_r;
  assign left_target   = left_r;
  assign right_target  = right_r;
  assign shovel_target = shovel_r;
  assign raw           = raw_r;

endmodule

/* hdl/sbus_frame_drive_mixer_top.sv */
// Top level of the SBUS frame drive mixer: configuration registers and the
// collector and mixer stages. Depends on sfdm_pkg, sfdm_collect and sfdm_mix.
//
//   Channel   Handshake               Payload
//   in_       in_valid / in_stall     in_serial_byte
//   out_      out_valid / out_stall   out_left_target .. out_channel_nine
//   cfg_      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low. Every 25th byte, counted
// from reset, closes a frame; its result passes through the collector stage
// register and then the result register. Other bytes give no result.
// Reset clears the byte count, the stage valids and loads the default registers.
// A stalled result holds; bytes keep flowing until a further frame end would
// need the occupied collector stage, and only that byte is stalled.
module sbus_frame_drive_mixer_top import sfdm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_serial_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DRIVE_W-1:0]  out_left_target,
  output logic signed [DRIVE_W-1:0]  out_right_target,
  output logic signed [SHOVEL_W-1:0] out_shovel_target,
  output logic [CH_W-1:0]            out_channel_three,
  output logic [CH_W-1:0]            out_channel_four,
  output logic [CH_W-1:0]            out_channel_five,
  output logic [CH_W-1:0]            out_channel_six,
  output logic [CH_W-1:0]            out_channel_seven,
  output logic [CH_W-1:0]            out_channel_eight,
  output logic [CH_W-1:0]            out_channel_nine,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CH_W-1:0]            cfg_data
);

  cfg_t                           cfg_r;
  cfg_t                           cfg_nxt;
  logic                           frame_valid;
  logic                           frame_ready;
  frame_t                         frame;
  logic [RAW_CHANS-1:0][CH_W-1:0] raw;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER:   cfg_nxt.center        = cfg_data;
        CFG_FLOOR:    cfg_nxt.floor         = cfg_data;
        CFG_DEADBAND: cfg_nxt.deadband      = cfg_data[DB_W-1:0];
        CFG_STRAIGHT: cfg_nxt.straight_gain = cfg_data[GAIN_W-1:0];
        CFG_TURN:     cfg_nxt.turn_gain     = cfg_data[GAIN_W-1:0];
        CFG_SHOVEL:   cfg_nxt.shovel_gain   = cfg_data[GAIN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center        <= CENTER_RST;
      cfg_r.floor         <= FLOOR_RST;
      cfg_r.deadband      <= DEADBAND_RST;
      cfg_r.straight_gain <= STRAIGHT_RST;
      cfg_r.turn_gain     <= TURN_RST;
      cfg_r.shovel_gain   <= SHOVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfdm_collect u_collect (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_serial_byte (in_serial_byte),
    .frame_valid    (frame_valid),
    .frame          (frame),
    .frame_ready    (frame_ready)
  );

  sfdm_mix u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .frame_valid   (frame_valid),
    .frame         (frame),
    .frame_ready   (frame_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_target   (out_left_target),
    .right_target  (out_right_target),
    .shovel_target (out_shovel_target),
    .raw           (raw)
  );

  assign out_channel_three = raw[0];
  assign out_channel_four  = raw[1];
  assign out_channel_five  = raw[2];
  assign out_channel_six   = raw[3];
  assign out_channel_seven = raw[4];
  assign out_channel_eight = raw[5];
  assign out_channel_nine  = raw[6];

endmodule
